/* rtl/aes128_block_encrypt_defines.svh */
// ----------------------------------------------------------------------------
// AES-128 assertion macros
// Shared assertion helpers for the AES-128 encryption pipeline.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, round constants and byte helpers for the round pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int NumRounds = 10;

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;

   typedef logic [7:0] byte_type;
   typedef byte_type [0:15] block_type;

   typedef struct packed {
      logic valid;
      logic busy;
   } cell_status_type;

   localparam byte_type SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam byte_type RCON [0:NumRounds-1] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic byte_type gf_double(input byte_type x);
      gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type to_block(input logic [63:0] hi, input logic [63:0] lo);
      block_type b;
      for (int n = 0; n < 8; n++) begin
         b[n]   = hi[63-8*n -: 8];
         b[n+8] = lo[63-8*n -: 8];
      end
      return b;
   endfunction

endpackage

/* rtl/aes_round_cell.sv */
// ----------------------------------------------------------------------------
// AES round cell
// One registered AES round with its own on-the-fly key expansion step.
// ----------------------------------------------------------------------------
module aes_round_cell #(
   parameter int RoundIdx = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  aes_pkg::block_type  in_state,
   input  aes_pkg::block_type  in_key,
   output logic                out_valid,
   output aes_pkg::block_type  out_state,
   output aes_pkg::block_type  out_key
);

   localparam bit LastRound = (RoundIdx == aes_pkg::NumRounds - 1);

   aes_pkg::block_type sub_st, mix_st, key_nx;
   aes_pkg::byte_type  t [0:3];
   aes_pkg::block_type state_ff, key_ff;
   logic valid_ff;

   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sub_st[r+4*c] = aes_pkg::SBOX[in_state[r + 4*((c+r) & 3)]];
      for (int c = 0; c < 4; c++) begin
         aes_pkg::byte_type a0, a1, a2, a3, all;
         a0 = sub_st[4*c]; a1 = sub_st[4*c+1]; a2 = sub_st[4*c+2]; a3 = sub_st[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         mix_st[4*c]   = a0 ^ all ^ aes_pkg::gf_double(a0 ^ a1);
         mix_st[4*c+1] = a1 ^ all ^ aes_pkg::gf_double(a1 ^ a2);
         mix_st[4*c+2] = a2 ^ all ^ aes_pkg::gf_double(a2 ^ a3);
         mix_st[4*c+3] = a3 ^ all ^ aes_pkg::gf_double(a3 ^ a0);
      end
      if (LastRound) mix_st = sub_st;
      // key schedule step: RotWord, SubWord, Rcon, then ripple xor
      t[0] = aes_pkg::SBOX[in_key[13]] ^ aes_pkg::RCON[RoundIdx];
      t[1] = aes_pkg::SBOX[in_key[14]];
      t[2] = aes_pkg::SBOX[in_key[15]];
      t[3] = aes_pkg::SBOX[in_key[12]];
      for (int n = 0; n < 4; n++) key_nx[n] = in_key[n] ^ t[n];
      for (int n = 4; n < 16; n++) key_nx[n] = in_key[n] ^ key_nx[n-4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         key_ff <= key_nx;
         for (int n = 0; n < 16; n++) state_ff[n] <= mix_st[n] ^ key_nx[n];
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key   = key_ff;

endmodule

/* rtl/aes128_block_encrypt.sv */
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Encrypts 128-bit blocks under the key in the two key registers.
// ----------------------------------------------------------------------------
// A fully unrolled pipeline of ten round cells plus an input AddRoundKey
// stage: a new block is accepted every cycle unless the chain stalls; the
// input stage loads on the accepting edge. The whole chain advances
// together and stalls when the result stage is held by rsp_ready low.
// Key registers are written through csr_; write them only while no
// block is in flight.
`include "aes128_block_encrypt_defines.svh"

module aes128_block_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plaintext_high,
   input  logic [63:0] req_plaintext_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_ciphertext_high,
   output logic [63:0] rsp_ciphertext_low
);

   localparam int N = aes_pkg::NumRounds;

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;
   logic                v   [0:N];
   aes_pkg::block_type  st  [0:N];
   aes_pkg::block_type  ky  [0:N];
   logic                v0_ff;
   aes_pkg::block_type  st0_ff, ky0_ff, pt, kin;
   aes_pkg::cell_status_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            aes_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
            aes_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // whole chain moves unless the last stage holds an untaken result
   assign advance   = !v[N] || rsp_ready;
   assign req_ready = advance;

   assign pt  = aes_pkg::to_block(req_plaintext_high, req_plaintext_low);
   assign kin = aes_pkg::to_block(key_high_ff, key_low_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
      if (advance) begin
         ky0_ff <= kin;
         for (int n = 0; n < 16; n++) st0_ff[n] <= pt[n] ^ kin[n];
      end
   end

   assign v[0] = v0_ff;
   assign st[0] = st0_ff;
   assign ky[0] = ky0_ff;

   for (genvar i = 0; i < N; i++) begin : g_round
      aes_round_cell #(.RoundIdx(i)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(v[i]), .in_state(st[i]), .in_key(ky[i]),
         .out_valid(v[i+1]), .out_state(st[i+1]), .out_key(ky[i+1])
      );
   end

   assign rsp_valid = v[N];
   always_comb begin
      for (int n = 0; n < 8; n++) begin
         rsp_ciphertext_high[63-8*n -: 8] = st[N][n];
         rsp_ciphertext_low[63-8*n -: 8]  = st[N][n+8];
      end
   end

   assign stat.valid = v[N];
   assign stat.busy  = !advance;

   `AES_ASSERT_IMPL(a_stall_ready, clock, reset, stat.busy, !req_ready,
      "input accepted while pipeline stalled")
   `AES_ASSERT_NEXT(a_hold_result, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_ciphertext_high) && $stable(rsp_ciphertext_low),
      "held result changed")
   `AES_ASSERT_NEXT(a_first_stage, clock, reset, req_valid && req_ready, v[0],
      "accepted block lost at first stage")

endmodule
